// File: hdl/script_variable_flag_alu_defines.svh
// Assertion macros for the script variable / flag ALU.
// Each macro expects clk and rst in scope of the asserting module.
`ifndef SCRIPT_VARIABLE_FLAG_ALU_DEFINES_SVH
`define SCRIPT_VARIABLE_FLAG_ALU_DEFINES_SVH

// Same-cycle implication, masked while rst is high.
`define SVFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while rst is high.
`define SVFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/svfa_pkg.sv
// Shared constants and types for the script variable / flag ALU.
// No dependencies; used by the channel interfaces and every module.
package svfa_pkg;

  localparam int WORD_W = 32;
  localparam int CNT_W  = $clog2(WORD_W);

  // operation bytes
  localparam logic [7:0] OP_ASSIGN = 8'h25;
  localparam logic [7:0] OP_MUL    = 8'h26;
  localparam logic [7:0] OP_DIV    = 8'h27;
  localparam logic [7:0] OP_MOD    = 8'h28;
  localparam logic [7:0] OP_ADD    = 8'h29;
  localparam logic [7:0] OP_SUB    = 8'h2A;
  localparam logic [7:0] OP_AND    = 8'h2B;
  localparam logic [7:0] OP_XOR    = 8'h2C;
  localparam logic [7:0] OP_OR     = 8'h2D;
  localparam logic [7:0] OP_INC    = 8'h2E;
  localparam logic [7:0] OP_DEC    = 8'h2F;

  // error codes
  localparam logic [1:0] ERR_OK   = 2'd0;
  localparam logic [1:0] ERR_VAR  = 2'd1;
  localparam logic [1:0] ERR_FLAG = 2'd2;
  localparam logic [1:0] ERR_OP   = 2'd3;

  typedef struct packed {
    logic rd;
    logic wr;
    logic is_flag;
  } store_req_t;

  typedef struct packed {
    logic [7:0]        op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
  } alu_req_t;

endpackage

// File: hdl/svfa_in_if.sv
// Input channel: one command word with valid/ready handshake.
// Depends on svfa_pkg for the word width.
interface svfa_in_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [7:0]                        alu_op;
  logic signed [svfa_pkg::WORD_W-1:0] target_index;
  logic signed [svfa_pkg::WORD_W-1:0] operand;

  modport source (output valid, cmd, alu_op, target_index, operand, input ready);
  modport sink   (input valid, cmd, alu_op, target_index, operand, output ready);
endinterface

// File: hdl/svfa_out_if.sv
// Output channel: one result word with valid/ready handshake.
// Depends on svfa_pkg for the word width.
interface svfa_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [svfa_pkg::WORD_W-1:0] value;
  logic [1:0]                        error_code;

  modport source (output valid, value, error_code, input ready);
  modport sink   (input valid, value, error_code, output ready);
endinterface

// File: hdl/svfa_store.sv
// Variable word memory and flag byte memory with a clearing pass after reset.
// Depends on svfa_pkg for the request struct.
module svfa_store #(
  parameter int VAR_COUNT       = 128,
  parameter int FLAG_BYTE_COUNT = 2304,
  localparam int VAR_AW  = $clog2(VAR_COUNT),
  localparam int FLAG_AW = $clog2(FLAG_BYTE_COUNT)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  svfa_pkg::store_req_t          ctl,
  input  logic [VAR_AW-1:0]             var_addr,
  input  logic [FLAG_AW-1:0]            flag_addr,
  input  logic [svfa_pkg::WORD_W-1:0]   wr_data,
  output logic [svfa_pkg::WORD_W-1:0]   rd_data,
  output logic                          clearing
);

  localparam int CLR_N = (VAR_COUNT > FLAG_BYTE_COUNT) ? VAR_COUNT : FLAG_BYTE_COUNT;
  localparam int CLR_W = $clog2(CLR_N);
  localparam logic [CLR_W-1:0] CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [CLR_W:0]   VAR_LIM  = (CLR_W + 1)'(VAR_COUNT);
  localparam logic [CLR_W:0]   FLAG_LIM = (CLR_W + 1)'(FLAG_BYTE_COUNT);

  logic [svfa_pkg::WORD_W-1:0] var_mem [VAR_COUNT];
  logic [7:0]                  flag_mem [FLAG_BYTE_COUNT];

  logic [CLR_W-1:0]            clr_cnt;
  logic [svfa_pkg::WORD_W-1:0] var_q;
  logic [7:0]                  flag_q;
  logic                        sel_flag;
  logic                        clr_var;
  logic                        clr_flag;

  assign clr_var  = {1'b0, clr_cnt} < VAR_LIM;
  assign clr_flag = {1'b0, clr_cnt} < FLAG_LIM;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_cnt == CLR_LAST) begin
        clearing <= 1'b0;
      end else begin
        clr_cnt <= clr_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_var) begin
        var_mem[clr_cnt[VAR_AW-1:0]] <= '0;
      end
    end else if (ctl.wr && !ctl.is_flag) begin
      var_mem[var_addr] <= wr_data;
    end
    if (ctl.rd) begin
      var_q <= var_mem[var_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      if (clr_flag) begin
        flag_mem[clr_cnt[FLAG_AW-1:0]] <= '0;
      end
    end else if (ctl.wr && ctl.is_flag) begin
      flag_mem[flag_addr] <= wr_data[7:0];
    end
    if (ctl.rd) begin
      flag_q   <= flag_mem[flag_addr];
      sel_flag <= ctl.is_flag;
    end
  end

  // flag bytes come back zero-extended
  assign rd_data = sel_flag ? {{(svfa_pkg::WORD_W - 8){1'b0}}, flag_q} : var_q;

endmodule

// File: hdl/svfa_serial_alu.sv
// Bit-serial ALU: serial adder and logic, shift-add multiply, restoring divide.
// Depends on svfa_pkg for operation codes and the request struct.
module svfa_serial_alu (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  svfa_pkg::alu_req_t          req,
  output logic                        done,
  output logic [svfa_pkg::WORD_W-1:0] result
);

  localparam int W = svfa_pkg::WORD_W;
  localparam logic [svfa_pkg::CNT_W-1:0] CNT_LAST = svfa_pkg::CNT_W'(W - 1);

  typedef enum logic [2:0] {
    A_IDLE, A_SERIAL, A_MUL, A_NEG_A, A_NEG_B, A_DIV, A_FIX
  } astate_t;

  astate_t                    state;
  logic [7:0]                 op;
  logic [W-1:0]               a_reg;
  logic [W-1:0]               b_reg;
  logic [W-1:0]               acc;
  logic [svfa_pkg::CNT_W-1:0] cnt;
  logic                       carry;
  logic                       q_neg;
  logic                       r_neg;

  logic         a_bit;
  logic         b_bit;
  logic         r_bit;
  logic         carry_next;
  logic [W-1:0] mul_sum;
  logic [W:0]   trial;
  logic [W-1:0] neg_src;
  logic [W-1:0] neg_out;
  logic         fix_neg;

  always_comb begin
    a_bit      = a_reg[0];
    b_bit      = b_reg[0] ^ (op == svfa_pkg::OP_SUB);
    carry_next = (a_bit & b_bit) | (carry & (a_bit ^ b_bit));
    case (op) inside
      svfa_pkg::OP_ASSIGN: r_bit = b_reg[0];
      svfa_pkg::OP_AND:    r_bit = a_bit & b_bit;
      svfa_pkg::OP_XOR:    r_bit = a_bit ^ b_bit;
      svfa_pkg::OP_OR:     r_bit = a_bit | b_bit;
      default:             r_bit = a_bit ^ b_bit ^ carry;
    endcase
  end

  assign mul_sum = acc + a_reg;
  assign trial   = {acc, a_reg[W-1]} - {1'b0, b_reg};

  // one negator serves both operand magnitudes and the final sign fix
  always_comb begin
    fix_neg = (op == svfa_pkg::OP_DIV) ? q_neg : r_neg;
    unique case (state)
      A_NEG_A: neg_src = a_reg;
      A_NEG_B: neg_src = b_reg;
      default: neg_src = (op == svfa_pkg::OP_DIV) ? a_reg : acc;
    endcase
    neg_out = ~neg_src + W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
      done  <= 1'b0;
    end else begin
      unique case (state)
        A_IDLE: begin
          done <= start && ((req.op == svfa_pkg::OP_DIV) || (req.op == svfa_pkg::OP_MOD))
                  && (req.b == '0);
          if (start) begin
            op    <= req.op;
            a_reg <= req.a;
            acc   <= '0;
            cnt   <= '0;
            // subtract adds the inverted operand plus one
            carry <= (req.op == svfa_pkg::OP_SUB);
            case (req.op) inside
              svfa_pkg::OP_MUL: begin
                b_reg <= req.b;
                state <= A_MUL;
              end
              svfa_pkg::OP_DIV, svfa_pkg::OP_MOD: begin
                b_reg <= req.b;
                if (req.b == '0) begin
                  // divide by zero: hand the target back untouched
                  result <= req.a;
                end else begin
                  q_neg <= req.a[W-1] ^ req.b[W-1];
                  r_neg <= req.a[W-1];
                  state <= A_NEG_A;
                end
              end
              svfa_pkg::OP_INC: begin
                b_reg <= W'(1);
                state <= A_SERIAL;
              end
              svfa_pkg::OP_DEC: begin
                b_reg <= '1;
                state <= A_SERIAL;
              end
              default: begin
                b_reg <= req.b;
                state <= A_SERIAL;
              end
            endcase
          end
        end
        A_SERIAL: begin
          acc   <= {r_bit, acc[W-1:1]};
          a_reg <= a_reg >> 1;
          b_reg <= b_reg >> 1;
          carry <= carry_next;
          cnt   <= cnt + 1'b1;
          done  <= (cnt == CNT_LAST);
          if (cnt == CNT_LAST) begin
            result <= {r_bit, acc[W-1:1]};
            state  <= A_IDLE;
          end
        end
        A_MUL: begin
          if (b_reg[0]) begin
            acc <= mul_sum;
          end
          a_reg <= a_reg << 1;
          b_reg <= b_reg >> 1;
          cnt   <= cnt + 1'b1;
          done  <= (cnt == CNT_LAST);
          if (cnt == CNT_LAST) begin
            result <= b_reg[0] ? mul_sum : acc;
            state  <= A_IDLE;
          end
        end
        A_NEG_A: begin
          done <= 1'b0;
          if (a_reg[W-1]) begin
            a_reg <= neg_out;
          end
          state <= A_NEG_B;
        end
        A_NEG_B: begin
          done <= 1'b0;
          if (b_reg[W-1]) begin
            b_reg <= neg_out;
          end
          state <= A_DIV;
        end
        A_DIV: begin
          done <= 1'b0;
          // shift one dividend bit into the remainder, quotient bit into a_reg
          acc   <= trial[W] ? {acc[W-2:0], a_reg[W-1]} : trial[W-1:0];
          a_reg <= {a_reg[W-2:0], ~trial[W]};
          cnt   <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= A_FIX;
          end
        end
        A_FIX: begin
          result <= fix_neg ? neg_out : neg_src;
          done   <= 1'b1;
          state  <= A_IDLE;
        end
        default: begin
          done  <= 1'b0;
          state <= A_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/script_variable_flag_alu.sv
// Script variable / flag ALU. Divide and modulo run the 32-step serial ALU loop
// plus a sign fix; a zero divisor, a bad op or a bad index ends the word early.
// One word in flight: the next word may be accepted in the cycle after the result
// is posted. Synchronous reset, then a clearing pass over max(VAR_COUNT,
// FLAG_BYTE_COUNT) addresses (2304 by default), with no input word accepted.
`include "script_variable_flag_alu_defines.svh"

module script_variable_flag_alu #(
  parameter int VAR_COUNT       = 128,
  parameter int FLAG_BYTE_COUNT = 2304
) (
  input  logic       clk,
  input  logic       rst,
  svfa_in_if.sink    req,
  svfa_out_if.source rsp
);

  localparam int W       = svfa_pkg::WORD_W;
  localparam int VAR_AW  = $clog2(VAR_COUNT);
  localparam int FLAG_AW = $clog2(FLAG_BYTE_COUNT);
  localparam logic [W-1:0] VAR_LIM  = W'(VAR_COUNT);
  localparam logic [W-4:0] FLAG_LIM = (W - 3)'(FLAG_BYTE_COUNT);

  typedef enum logic [2:0] {T_IDLE, T_CHECK, T_LOAD, T_ALU, T_DONE} state_t;

  state_t       state;
  logic         is_flag;
  logic [7:0]   op_r;
  logic [W-1:0] idx_r;
  logic [W-1:0] rhs_r;
  logic [W-1:0] res_r;
  logic [1:0]   err_r;

  logic                 idx_bad;
  logic                 op_ok;
  logic                 clearing;
  logic [W-1:0]         rd_data;
  logic                 alu_start;
  logic                 alu_done;
  logic [W-1:0]         alu_result;
  svfa_pkg::alu_req_t   alu_in;
  svfa_pkg::store_req_t st_req;

  assign idx_bad = is_flag ? ((idx_r[2:0] != 3'd0) || (idx_r[W-1:3] >= FLAG_LIM))
                           : (idx_r >= VAR_LIM);
  assign op_ok   = (op_r >= svfa_pkg::OP_ASSIGN) && (op_r <= svfa_pkg::OP_DEC);

  assign req.ready = (state == T_IDLE) && !clearing;

  assign st_req.rd      = (state == T_CHECK) && !idx_bad;
  assign st_req.wr      = (state == T_ALU) && alu_done;
  assign st_req.is_flag = is_flag;

  assign alu_start = (state == T_LOAD) && op_ok;
  assign alu_in.op = op_r;
  assign alu_in.a  = rd_data;
  assign alu_in.b  = rhs_r;

  svfa_store #(
    .VAR_COUNT       (VAR_COUNT),
    .FLAG_BYTE_COUNT (FLAG_BYTE_COUNT)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (st_req),
    .var_addr  (idx_r[VAR_AW-1:0]),
    .flag_addr (idx_r[FLAG_AW+2:3]),
    .wr_data   (alu_result),
    .rd_data   (rd_data),
    .clearing  (clearing)
  );

  svfa_serial_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .req    (alu_in),
    .done   (alu_done),
    .result (alu_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      rsp.valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one is loaded this cycle
      if (rsp.valid && rsp.ready && (state != T_DONE)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        T_IDLE: begin
          if (req.valid && req.ready) begin
            is_flag <= req.cmd;
            op_r    <= req.alu_op;
            idx_r   <= $unsigned(req.target_index);
            rhs_r   <= $unsigned(req.operand);
            state   <= T_CHECK;
          end
        end
        T_CHECK: begin
          if (idx_bad) begin
            res_r <= '0;
            err_r <= is_flag ? svfa_pkg::ERR_FLAG : svfa_pkg::ERR_VAR;
            state <= T_DONE;
          end else begin
            state <= T_LOAD;
          end
        end
        T_LOAD: begin
          if (!op_ok) begin
            res_r <= rd_data;
            err_r <= svfa_pkg::ERR_OP;
            state <= T_DONE;
          end else begin
            err_r <= svfa_pkg::ERR_OK;
            state <= T_ALU;
          end
        end
        T_ALU: begin
          if (alu_done) begin
            res_r <= alu_result;
            state <= T_DONE;
          end
        end
        T_DONE: begin
          // hold until the output register is free
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.value      <= $signed(res_r);
            rsp.error_code <= err_r;
            state          <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  `SVFA_ASSERT_NOW(a_no_take_while_clearing, clearing, !req.ready,
                   "word taken during clear")
  `SVFA_ASSERT_NOW(a_index_err_zero_value,
                   rsp.valid && (rsp.error_code == svfa_pkg::ERR_VAR ||
                                 rsp.error_code == svfa_pkg::ERR_FLAG),
                   rsp.value == '0, "index error with nonzero value")
  `SVFA_ASSERT_NOW(a_write_only_ok, st_req.wr,
                   err_r == svfa_pkg::ERR_OK && !idx_bad, "store write on error")
  `SVFA_ASSERT_NOW(a_alu_done_in_wait, alu_done, state == T_ALU,
                   "alu done outside wait state")
  `SVFA_ASSERT_NEXT(a_accept_to_check, req.valid && req.ready, state == T_CHECK,
                    "accepted word not checked")

endmodule

// File: sim/svfa_result_checker.sv
// Result checker for the script variable / flag ALU: watches both channels,
// predicts each result from its own copy of the variable and flag stores, compares.
// Depends on svfa_pkg and the svfa_in_if / svfa_out_if channel interfaces.
module svfa_result_checker #(
  parameter int VAR_COUNT       = 128,
  parameter int FLAG_BYTE_COUNT = 2304
) (
  input  logic clk,
  input  logic rst,
  svfa_in_if   req,
  svfa_out_if  rsp,
  output int   mismatch_count,
  output int   pending_count,
  output int   checked_count,
  output int   error_result_count
);
  import svfa_pkg::*;

  typedef struct packed {
    logic [WORD_W-1:0] value;
    logic [1:0]        code;
  } alu_result_t;

  logic [WORD_W-1:0] var_words [VAR_COUNT];
  logic [7:0]        flag_bytes [FLAG_BYTE_COUNT];
  alu_result_t       predicted_results [$];

  function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] x);
    return x[WORD_W-1] ? ('0 - x) : x;
  endfunction

  // Return 0 for an unknown operation; res then holds cur.
  function automatic logic alu_apply(input logic [7:0] op, input logic [WORD_W-1:0] cur,
                                     input logic [WORD_W-1:0] rhs,
                                     output logic [WORD_W-1:0] res);
    logic [WORD_W-1:0] quo;
    logic [WORD_W-1:0] rem;
    res = cur;
    alu_apply = 1'b1;
    case (op)
      OP_ASSIGN: res = rhs;
      OP_MUL:    res = cur * rhs;
      OP_DIV: begin
        if (rhs != '0) begin
          quo = magnitude(cur) / magnitude(rhs);
          res = (cur[WORD_W-1] ^ rhs[WORD_W-1]) ? ('0 - quo) : quo;
        end
      end
      OP_MOD: begin
        // remainder follows the sign of the dividend
        if (rhs != '0) begin
          rem = magnitude(cur) % magnitude(rhs);
          res = cur[WORD_W-1] ? ('0 - rem) : rem;
        end
      end
      OP_ADD: res = cur + rhs;
      OP_SUB: res = cur - rhs;
      OP_AND: res = cur & rhs;
      OP_XOR: res = cur ^ rhs;
      OP_OR:  res = cur | rhs;
      OP_INC: res = cur + 1'b1;
      OP_DEC: res = cur - 1'b1;
      default: alu_apply = 1'b0;
    endcase
  endfunction

  function automatic alu_result_t predict_command(input logic kind, input logic [7:0] op,
                                                  input logic [WORD_W-1:0] idx,
                                                  input logic [WORD_W-1:0] rhs);
    alu_result_t       out;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] res;
    logic [WORD_W-1:0] byte_no;
    out.value = '0;
    out.code  = ERR_OK;
    byte_no   = idx >> 3;
    if (!kind) begin
      if (idx >= 32'(VAR_COUNT)) begin
        out.code = ERR_VAR;
      end else begin
        cur = var_words[idx];
        if (alu_apply(op, cur, rhs, res)) var_words[idx] = res;
        else out.code = ERR_OP;
        out.value = res;
      end
    end else begin
      if (idx[2:0] != 3'd0 || byte_no >= 32'(FLAG_BYTE_COUNT)) begin
        out.code = ERR_FLAG;
      end else begin
        // zero-extend the byte, keep only the low byte on write-back
        cur = {{(WORD_W-8){1'b0}}, flag_bytes[byte_no]};
        if (alu_apply(op, cur, rhs, res)) flag_bytes[byte_no] = res[7:0];
        else out.code = ERR_OP;
        out.value = res;
      end
    end
    return out;
  endfunction

  initial begin
    mismatch_count     = 0;
    pending_count      = 0;
    checked_count      = 0;
    error_result_count = 0;
  end

  always @(posedge clk) begin
    alu_result_t want;
    if (rst) begin
      foreach (var_words[i]) var_words[i] = '0;
      foreach (flag_bytes[i]) flag_bytes[i] = '0;
      predicted_results.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (predicted_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result word, expected none, got value %08h code %0d",
                   $time, rsp.value, rsp.error_code);
        end else begin
          want = predicted_results.pop_front();
          checked_count++;
          if (want.code != ERR_OK) error_result_count++;
          if (rsp.value !== want.value) begin
            mismatch_count++;
            $display("%0t: value mismatch, expected %08h, got %08h",
                     $time, want.value, rsp.value);
          end
          if (rsp.error_code !== want.code) begin
            mismatch_count++;
            $display("%0t: error_code mismatch, expected %0d, got %0d",
                     $time, want.code, rsp.error_code);
          end
        end
      end
      if (req.valid && req.ready)
        predicted_results.push_back(predict_command(req.cmd, req.alu_op,
                                                    req.target_index, req.operand));
    end
    pending_count = predicted_results.size();
  end
endmodule

// File: sim/tb.sv
// Top of the script variable / flag ALU testbench: clock, reset, command stimulus,
// random output stalls, idle watchdog and verdict.
// Depends on svfa_pkg, the channel interfaces, the DUT and svfa_result_checker.
module tb;
  import svfa_pkg::*;

  localparam int VAR_COUNT       = 128;
  localparam int FLAG_BYTE_COUNT = 2304;
  localparam int RANDOM_WORDS    = 1125;
  localparam int IDLE_LIMIT      = 10000;
  localparam int DRAIN_CYCLES    = 60;

  localparam logic              CMD_VAR  = 1'b0;
  localparam logic              CMD_FLAG = 1'b1;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] VAR_LAST = VAR_COUNT - 1;
  localparam logic [WORD_W-1:0] FLAG_LAST_BIT = (FLAG_BYTE_COUNT - 1) * 8;
  localparam logic [7:0]        BAD_OP_ZERO = 8'h00;
  localparam logic [7:0]        BAD_OP_HIGH = 8'hFF;

  logic clk = 1'b0;
  logic rst;

  svfa_in_if  req_chan ();
  svfa_out_if rsp_chan ();

  int   mismatch_count;
  int   pending_count;
  int   checked_count;
  int   error_result_count;
  int   words_sent;
  int   directed_words;
  int   idle_cycles;
  int   stall_left;
  logic sender_calm;
  logic receiver_calm;

  always #10 clk = ~clk;

  script_variable_flag_alu #(
    .VAR_COUNT      (VAR_COUNT),
    .FLAG_BYTE_COUNT(FLAG_BYTE_COUNT)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_chan),
    .rsp(rsp_chan)
  );

  svfa_result_checker #(
    .VAR_COUNT      (VAR_COUNT),
    .FLAG_BYTE_COUNT(FLAG_BYTE_COUNT)
  ) i_checker (
    .clk               (clk),
    .rst               (rst),
    .req               (req_chan),
    .rsp               (rsp_chan),
    .mismatch_count    (mismatch_count),
    .pending_count     (pending_count),
    .checked_count     (checked_count),
    .error_result_count(error_result_count)
  );

  // Mostly short pauses, a few long ones; none while calm.
  function automatic int pick_pause(input logic calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Call right after a rising edge; returns at the edge that accepts the word.
  task automatic send_word(input logic kind, input logic [7:0] op,
                           input logic [WORD_W-1:0] idx, input logic [WORD_W-1:0] rhs);
    int pause;
    if ($urandom_range(0, 39) == 0) sender_calm = !sender_calm;
    pause = pick_pause(sender_calm);
    if (pause > 0) begin
      req_chan.valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    req_chan.valid        <= 1'b1;
    req_chan.cmd          <= kind;
    req_chan.alu_op       <= op;
    req_chan.target_index <= idx;
    req_chan.operand      <= rhs;
    @(posedge clk);
    while (!req_chan.ready) @(posedge clk);
    words_sent++;
  endtask

  // Output side: random stalls on ready.
  initial begin
    rsp_chan.ready <= 1'b0;
    stall_left    = 0;
    receiver_calm = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 249) == 0) receiver_calm = !receiver_calm;
      if (stall_left > 0) begin
        rsp_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_chan.ready <= 1'b1;
        stall_left = pick_pause(receiver_calm);
      end
    end
  end

  // Watchdog: covers the clearing pass after reset plus the slowest word.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic              kind;
    logic [7:0]        op;
    logic [WORD_W-1:0] idx;
    logic [WORD_W-1:0] rhs;
    int                roll;

    words_sent  = 0;
    sender_calm = 1'b0;
    rst                   <= 1'b1;
    req_chan.valid        <= 1'b0;
    req_chan.cmd          <= CMD_VAR;
    req_chan.alu_op       <= OP_ASSIGN;
    req_chan.target_index <= '0;
    req_chan.operand      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // minimum value divided by -1, zero divisors, modulo by -1
    send_word(CMD_VAR, OP_ASSIGN, VAR_LAST, WORD_MIN);
    send_word(CMD_VAR, OP_DIV, VAR_LAST, ALL_ONES);
    send_word(CMD_VAR, OP_DIV, VAR_LAST, '0);
    send_word(CMD_VAR, OP_MOD, VAR_LAST, '0);
    send_word(CMD_VAR, OP_MOD, VAR_LAST, ALL_ONES);
    // wrap on inc, dec and multiply
    send_word(CMD_VAR, OP_ASSIGN, '0, WORD_MAX);
    send_word(CMD_VAR, OP_INC, '0, '0);
    send_word(CMD_VAR, OP_DEC, '0, '0);
    send_word(CMD_VAR, OP_MUL, '0, WORD_MAX);
    // negative dividend: remainder keeps its sign, quotient truncates to zero
    send_word(CMD_VAR, OP_ASSIGN, 32'd1, 32'hFFFF_FFF9);
    send_word(CMD_VAR, OP_MOD, 32'd1, 32'd2);
    send_word(CMD_VAR, OP_DIV, 32'd1, 32'd2);
    send_word(CMD_VAR, OP_ADD, 32'd2, ALL_ONES);
    send_word(CMD_VAR, OP_SUB, 32'd2, WORD_MIN);
    send_word(CMD_VAR, OP_AND, 32'd2, 32'h0F0F_0F0F);
    send_word(CMD_VAR, OP_XOR, 32'd2, ALL_ONES);
    send_word(CMD_VAR, OP_OR, 32'd2, 32'h8000_0001);
    // flag byte: full value returned, low byte kept
    send_word(CMD_FLAG, OP_ASSIGN, '0, 32'h0000_01FF);
    send_word(CMD_FLAG, OP_INC, '0, '0);
    send_word(CMD_FLAG, OP_XOR, FLAG_LAST_BIT, ALL_ONES);
    // bad indexes: past the end, misaligned, negative
    send_word(CMD_FLAG, OP_ASSIGN, FLAG_LAST_BIT + 32'd8, 32'd5);
    send_word(CMD_FLAG, OP_ASSIGN, 32'd3, 32'd5);
    send_word(CMD_FLAG, OP_ASSIGN, 32'hFFFF_FFF8, 32'd5);
    send_word(CMD_VAR, OP_ASSIGN, VAR_LAST + 32'd1, 32'd5);
    send_word(CMD_VAR, OP_ASSIGN, ALL_ONES, 32'd5);
    // bad operations, and bad index together with a bad operation
    send_word(CMD_VAR, BAD_OP_ZERO, '0, 32'd5);
    send_word(CMD_FLAG, BAD_OP_HIGH, FLAG_LAST_BIT, 32'd5);
    send_word(CMD_VAR, OP_DEC + 8'd1, VAR_LAST, 32'd5);
    send_word(CMD_VAR, BAD_OP_ZERO, 32'd200, 32'd5);
    directed_words = words_sent;

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      kind = 1'($urandom_range(0, 1));
      roll = $urandom_range(0, 99);
      if (roll < 88) begin
        // favor a few hot entries so values build up across operations
        if (kind == CMD_VAR)
          idx = (roll < 60) ? $urandom_range(0, 15) : $urandom_range(0, VAR_COUNT - 1);
        else
          idx = ((roll < 60) ? $urandom_range(0, 7)
                             : $urandom_range(0, FLAG_BYTE_COUNT - 1)) << 3;
      end else begin
        case ($urandom_range(0, 3))
          0: idx = $urandom;
          1: idx = 32'd0 - $urandom_range(1, 4096);
          2: begin
            if (kind == CMD_VAR) idx = $urandom_range(VAR_COUNT, 4 * VAR_COUNT);
            else idx = ($urandom_range(0, FLAG_BYTE_COUNT - 1) << 3) | $urandom_range(1, 7);
          end
          default: idx = $urandom_range(FLAG_BYTE_COUNT, 2 * FLAG_BYTE_COUNT) << 3;
        endcase
      end

      roll = $urandom_range(0, 99);
      if (roll < 90) op = 8'($urandom_range(OP_ASSIGN, OP_DEC));
      else op = 8'($urandom_range(0, 255));

      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        case ($urandom_range(0, 4))
          0: rhs = '0;
          1: rhs = 32'd1;
          2: rhs = ALL_ONES;
          3: rhs = WORD_MIN;
          default: rhs = WORD_MAX;
        endcase
      end else if (roll < 50) begin
        rhs = $urandom_range(0, 20) - 10;
      end else begin
        rhs = $urandom;
      end

      send_word(kind, op, idx, rhs);
    end
    req_chan.valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d command words (%0d directed) to the variable and flag stores;",
             words_sent, directed_words);
    $display("checked %0d results, %0d of them with an error code.",
             checked_count, error_result_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
